// ===== rtl/bounded_list_insert_delete_top_assert.svh =====
// Assertion macros used by the bounded list sequencer (bli_ctrl).
// No dependencies; include by bare file name where checks are written.
`ifndef BOUNDED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define BOUNDED_LIST_INSERT_DELETE_TOP_ASSERT_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define BLI_ASSERT_NOW(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("bounded list check failed");

// Whenever the condition holds, the consequence must hold in the following cycle.
`define BLI_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("bounded list check failed");

`endif

// ===== rtl/bli_pkg.sv =====
// Package for the bounded list: command and result word types, cell controls.
// No dependencies.
`default_nettype none

package bli_pkg;

  localparam int unsigned CNT_W  = 7;
  localparam int unsigned DATA_W = 32;

  // Operation codes carried in the command word.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_DELETE     = 2'd2
  } op_e;

  // What every cell in the chain does in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] item_value;
    logic [CNT_W-1:0]         position;
  } cmd_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     last_of_list;
    logic                     list_empty;
    logic                     insert_dropped;
  } result_word_t;

  // Broadcast to all cells: command, reference position and data word.
  typedef struct packed {
    cell_cmd_e                cmd;
    logic [CNT_W-1:0]         ref_idx;
    logic signed [DATA_W-1:0] data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bli_cell.sv =====
// One storage cell of the list chain; takes its neighbors' words or the broadcast.
// Depends on bli_pkg.
`default_nettype none

module bli_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire                              clk_i,
  input  bli_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic signed [31:0]          prev_i,
  input  wire logic signed [31:0]          next_i,
  output logic signed [31:0]               value_o
);
  import bli_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(Idx);

  logic signed [DATA_W-1:0] value_d, value_q;

  // Each cell decides from its own position what it loads.
  always_comb begin
    value_d = value_q;
    case (ctrl_i.cmd)
      CELL_PUSH_FRONT: begin
        value_d = (MyIdx == '0) ? ctrl_i.data : prev_i;
      end
      CELL_PUSH_BACK: begin
        if (MyIdx == ctrl_i.ref_idx) value_d = ctrl_i.data;
      end
      CELL_REMOVE: begin
        if (MyIdx >= ctrl_i.ref_idx) value_d = next_i;
      end
      CELL_ROTATE: begin
        if (MyIdx == ctrl_i.ref_idx) begin
          value_d = ctrl_i.data;
        end else if (MyIdx < ctrl_i.ref_idx) begin
          value_d = next_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== rtl/bli_ctrl.sv =====
// Sequencer of the bounded list: decodes commands, tracks the fill count,
// rotates the chain to stream the list out. Depends on bli_pkg and the assert header.
`default_nettype none
`include "bounded_list_insert_delete_top_assert.svh"

module bli_ctrl #(
  parameter int unsigned Capacity = 64
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  bli_pkg::cmd_word_t          cmd_i,
  input  wire logic signed [31:0]     head_i,
  output bli_pkg::cell_ctrl_t         cell_ctrl_o,
  output logic                        busy_o,
  output logic                        result_valid_o,
  output bli_pkg::result_word_t       result_o
);
  import bli_pkg::*;

  localparam logic [CNT_W-1:0] Full = CNT_W'(Capacity);

  ctrl_state_e      state_d, state_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic [CNT_W-1:0] idx_d, idx_q;
  logic             dropped_d, dropped_q;
  logic             out_valid_d, out_valid_q;
  result_word_t     out_d, out_q;
  logic [CNT_W-1:0] last_idx;

  assign last_idx = count_q - 1'b1;

  // Next state, cell commands and the outgoing word.
  always_comb begin
    state_d             = state_q;
    count_d             = count_q;
    idx_d               = idx_q;
    dropped_d           = dropped_q;
    out_valid_d         = 1'b0;
    out_d               = out_q;
    cell_ctrl_o.cmd     = CELL_HOLD;
    cell_ctrl_o.ref_idx = count_q;
    cell_ctrl_o.data    = cmd_i.item_value;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          idx_d     = '0;
          dropped_d = 1'b0;
          state_d   = ST_EMIT;
          case (cmd_i.opcode)
            OP_PUSH_FRONT: begin
              if (count_q >= Full) begin
                dropped_d = 1'b1;
              end else begin
                cell_ctrl_o.cmd = CELL_PUSH_FRONT;
                count_d         = count_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (count_q >= Full) begin
                dropped_d = 1'b1;
              end else begin
                cell_ctrl_o.cmd = CELL_PUSH_BACK;
                count_d         = count_q + 1'b1;
              end
            end
            OP_DELETE: begin
              if (cmd_i.position < count_q) begin
                cell_ctrl_o.cmd     = CELL_REMOVE;
                cell_ctrl_o.ref_idx = cmd_i.position;
                count_d             = count_q - 1'b1;
              end
            end
            default: begin
              cell_ctrl_o.cmd = CELL_HOLD;
            end
          endcase
        end
      end
      ST_EMIT: begin
        out_valid_d          = 1'b1;
        out_d.insert_dropped = dropped_q;
        if (count_q == '0) begin
          // An empty list reports a single zero word.
          out_d.element      = '0;
          out_d.last_of_list = 1'b1;
          out_d.list_empty   = 1'b1;
          state_d            = ST_IDLE;
        end else begin
          // Send the head and rotate it to the back of the used part.
          cell_ctrl_o.cmd     = CELL_ROTATE;
          cell_ctrl_o.ref_idx = last_idx;
          cell_ctrl_o.data    = head_i;
          out_d.element       = head_i;
          out_d.last_of_list  = (idx_q == last_idx);
          out_d.list_empty    = 1'b0;
          idx_d               = idx_q + 1'b1;
          if (idx_q == last_idx) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result word itself needs no reset.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  // The fill count never passes the capacity.
  `BLI_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= Full)
  // An accepted command always leads into the listing phase.
  `BLI_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // The listing index stays inside the used part of the chain.
  `BLI_ASSERT_NOW(a_idx_range, clk_i, rst_ni, state_q == ST_EMIT && count_q != '0, idx_q < count_q)
  // An empty report is a single, final, zero word.
  `BLI_ASSERT_NOW(a_empty_word, clk_i, rst_ni, out_valid_q && out_q.list_empty, out_q.last_of_list && out_q.element == '0)

endmodule

`default_nettype wire

// ===== rtl/bounded_list_insert_delete_top.sv =====
// Bounded list top: a command word is accepted when start_i is high and busy_o low.
// The first result word is strobed from the output register once the sequencer is listing.
// A new command is taken only after every word of the list, as it stands after
// the operation, has been sent; the chain rotates one word per cycle to stream the list out.
// Result words are strobed for one cycle each; the receiver cannot stall them.
// Reset (rst_ni low, asynchronous) empties the list; cell contents are not cleared.
`default_nettype none

module bounded_list_insert_delete_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  bli_pkg::cmd_word_t     cmd_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output bli_pkg::result_word_t  result_o
);
  import bli_pkg::*;

  cell_ctrl_t               cell_ctrl;
  logic signed [DATA_W-1:0] cell_val [CAPACITY];

  // Sequencer and output register.
  bli_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .head_i         (cell_val[0]),
    .cell_ctrl_o    (cell_ctrl),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Chain of cells, each wired to its left and right neighbor.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [DATA_W-1:0] prev_w, next_w;
    if (k == 0) begin : g_first
      assign prev_w = cell_val[k];
    end else begin : g_mid_prev
      assign prev_w = cell_val[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign next_w = cell_val[k];
    end else begin : g_mid_next
      assign next_w = cell_val[k+1];
    end
    bli_cell #(
      .Idx (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .value_o (cell_val[k])
    );
  end

endmodule

`default_nettype wire

// ===== sim/bli_checker.sv =====
// Scoreboard for the bounded list: watches the command and result channels,
// keeps its own copy of the list and compares every result word field by field.
// Depends on bli_pkg for the command and result word types and the operation codes.
`timescale 1ns / 1ps

module bli_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire                   busy_i,
  input  bli_pkg::cmd_word_t    cmd_i,
  input  wire                   result_valid_i,
  input  bli_pkg::result_word_t result_i,
  output int                    error_count_o,
  output int                    words_pending_o
);
  import bli_pkg::*;

  // Shadow copy of the list contents, front first.
  logic signed [DATA_W-1:0] shadow_list[$];
  // Result words still owed by the block, oldest first.
  result_word_t listing_words[$];
  int mismatch_total;

  // Apply one command to the shadow list and queue the listing it produces.
  task automatic apply_command(input cmd_word_t cmd);
    logic         refused;
    result_word_t word;
    refused = 1'b0;
    case (cmd.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_list.size() >= CAPACITY) begin
          refused = 1'b1;
        end else if (cmd.opcode == OP_PUSH_FRONT) begin
          shadow_list.push_front(cmd.item_value);
        end else begin
          shadow_list.push_back(cmd.item_value);
        end
      end
      OP_DELETE: begin
        if (int'(cmd.position) < shadow_list.size()) begin
          shadow_list.delete(int'(cmd.position));
        end
      end
      default: ;
    endcase

    // An empty list is reported as a single word marked empty.
    if (shadow_list.size() == 0) begin
      word.element        = '0;
      word.last_of_list   = 1'b1;
      word.list_empty     = 1'b1;
      word.insert_dropped = refused;
      listing_words.push_back(word);
    end else begin
      foreach (shadow_list[k]) begin
        word.element        = shadow_list[k];
        word.last_of_list   = (k == shadow_list.size() - 1);
        word.list_empty     = 1'b0;
        word.insert_dropped = refused;
        listing_words.push_back(word);
      end
    end
  endtask

  // Field-by-field comparison of one result word against its expectation.
  task automatic compare_word(input result_word_t want, input result_word_t got);
    if (got.element !== want.element) begin
      $error("element: expected %0d, actual %0d", want.element, got.element);
      mismatch_total++;
    end
    if (got.last_of_list !== want.last_of_list) begin
      $error("last_of_list: expected %0b, actual %0b", want.last_of_list, got.last_of_list);
      mismatch_total++;
    end
    if (got.list_empty !== want.list_empty) begin
      $error("list_empty: expected %0b, actual %0b", want.list_empty, got.list_empty);
      mismatch_total++;
    end
    if (got.insert_dropped !== want.insert_dropped) begin
      $error("insert_dropped: expected %0b, actual %0b",
             want.insert_dropped, got.insert_dropped);
      mismatch_total++;
    end
  endtask

  // Results are checked before a command on the same edge is applied.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_list.delete();
      listing_words.delete();
      mismatch_total   = 0;
      error_count_o   <= 0;
      words_pending_o <= 0;
    end else begin
      if (result_valid_i === 1'b1) begin
        if (listing_words.size() == 0) begin
          $error("result word with no expectation: element %0d", result_i.element);
          mismatch_total++;
        end else begin
          compare_word(listing_words.pop_front(), result_i);
        end
      end
      if (start_i && !busy_i) begin
        apply_command(cmd_i);
      end
      words_pending_o <= listing_words.size();
      error_count_o   <= mismatch_total;
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the bounded list: clock, reset, command stimulus in bursts
// and the final verdict. Depends on bli_pkg, the block and bli_checker.
`timescale 1ns / 1ps

module tb;
  import bli_pkg::*;

  localparam int unsigned LIST_CAP     = 64;
  localparam int          RANDOM_WORDS = 500;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic         clk_i   = 1'b0;
  logic         rst_ni  = 1'b0;
  logic         start_i = 1'b0;
  cmd_word_t    cmd_i   = '0;
  logic         busy_o;
  logic         result_valid_o;
  result_word_t result_o;

  int fail_count;
  int words_pending;

  // Stimulus-side length estimate, used only to aim delete positions.
  int list_len    = 0;
  int burst_left  = 0;
  int random_sent = 0;

  bounded_list_insert_delete_top #(.CAPACITY(LIST_CAP)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  bli_checker #(.CAPACITY(LIST_CAP)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .cmd_i           (cmd_i),
    .result_valid_i  (result_valid_o),
    .result_i        (result_o),
    .error_count_o   (fail_count),
    .words_pending_o (words_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Values lean toward the signed extremes, zero and all ones.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Delete positions mostly hit the list, some land just past the end or anywhere.
  function automatic logic [6:0] pick_position();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14 && list_len > 0) return 7'($urandom_range(0, list_len - 1));
    if (r < 17) return 7'((list_len + $urandom_range(0, 3) > 127) ? 127 :
                          list_len + $urandom_range(0, 3));
    return 7'($urandom_range(0, 127));
  endfunction

  // Present one command word, hold it until accepted, then maybe open a gap.
  task automatic send_word(input logic [1:0] op, input logic [31:0] val,
                           input logic [6:0] pos);
    cmd_word_t word;
    logic      was_busy;
    int        gap;
    word.opcode     = op;
    word.item_value = val;
    word.position   = pos;
    start_i <= 1'b1;
    cmd_i   <= word;
    do begin
      @(negedge clk_i);
      was_busy = busy_o;
      @(posedge clk_i);
    end while (was_busy);

    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      if (list_len < LIST_CAP) list_len++;
    end else if (op == OP_DELETE && int'(pos) < list_len) begin
      list_len--;
    end

    // Bursts of back-to-back words, separated by gaps of varied length.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                 : $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        6, 7:             gap = $urandom_range(4, 20);
        default:          gap = $urandom_range(20, 80);
      endcase
      start_i <= 1'b0;
      cmd_i   <= cmd_word_t'($bits(cmd_word_t)'({$urandom, $urandom}));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random opcode for the fill and drain phases.
  task automatic send_insert();
    send_word($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value(),
              7'($urandom_range(0, 127)));
  endtask

  task automatic send_delete();
    send_word(OP_DELETE, $urandom, pick_position());
  endtask

  initial begin
    int phase;
    int run;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: empty list, extremes, deletes past the end, unused opcode.
    send_word(OP_DELETE,     32'h0000_0000, 7'd0);
    send_word(OP_UNUSED,     32'hffff_ffff, 7'd127);
    send_word(OP_PUSH_FRONT, 32'h8000_0000, 7'd127);
    send_word(OP_PUSH_BACK,  32'h7fff_ffff, 7'd0);
    send_word(OP_PUSH_FRONT, 32'h0000_0000, 7'd0);
    send_word(OP_PUSH_BACK,  32'hffff_ffff, 7'd127);
    send_word(OP_DELETE,     32'hffff_ffff, 7'd127);
    send_word(OP_DELETE,     32'h0000_0000, 7'd4);
    send_word(OP_DELETE,     32'h0000_0000, 7'd1);
    send_word(OP_PUSH_BACK,  32'h5555_5555, 7'd0);
    send_word(OP_PUSH_FRONT, 32'haaaa_aaaa, 7'd0);
    send_word(OP_UNUSED,     32'h1234_5678, 7'd2);
    send_word(OP_DELETE,     32'h0000_0000, 7'd0);
    send_word(OP_DELETE,     32'h0000_0000, 7'd3);
    send_word(OP_DELETE,     32'h0000_0000, 7'd0);
    send_word(OP_DELETE,     32'h0000_0000, 7'd0);
    send_word(OP_DELETE,     32'h0000_0000, 7'd0);
    send_word(OP_DELETE,     32'h0000_0000, 7'd0);

    // Random phases: fill runs drive the list to full and past it, drains empty it.
    while (random_sent < RANDOM_WORDS) begin
      phase = $urandom_range(0, 4);
      case (phase)
        0, 1:    run = $urandom_range(10, 80);
        2, 3:    run = $urandom_range(10, 70);
        default: run = $urandom_range(5, 30);
      endcase
      repeat (run) begin
        case (phase)
          0, 1: begin
            if ($urandom_range(0, 9) == 0) send_delete();
            else send_insert();
          end
          2, 3: begin
            case ($urandom_range(0, 19))
              0, 1:    send_insert();
              2:       send_word(OP_UNUSED, $urandom, 7'($urandom_range(0, 127)));
              default: send_delete();
            endcase
          end
          default: begin
            send_word(2'($urandom_range(0, 3)), pick_value(), 7'($urandom_range(0, 127)));
          end
        endcase
        random_sent++;
      end
    end

    // Drain: wait for every owed word, then watch for strays.
    start_i <= 1'b0;
    @(posedge clk_i);
    wait (words_pending == 0);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bounded_list_insert_delete_top regression: pass");
    end else begin
      $display("bounded_list_insert_delete_top regression: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("bounded_list_insert_delete_top regression: fail");
    $finish;
  end

endmodule
